### rtl/core/aabt_pkg.sv
// shared widths, codes and control types of the angle alpha-beta tracker
package aabt_pkg;

  localparam int unsigned ANGLE_W  = 24;
  localparam int unsigned SPEED_W  = 32;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned ALPHA_W  = 17;
  localparam int unsigned BETA_W   = 32;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // multiplier operands are 33-bit signed, only the low product bits are kept
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 57;

  localparam logic [PROD_W-1:0] RND_24 = PROD_W'(1) << 23;
  localparam logic [PROD_W-1:0] RND_16 = PROD_W'(1) << 15;

  localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

  localparam logic [SPEED_W-1:0]  SPEED_RST  = '0;
  localparam logic [ANGLE_W-1:0]  ANGLE_RST  = '0;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(214748);
  localparam logic [ALPHA_W-1:0]  ALPHA_RST  = '0;
  localparam logic [BETA_W-1:0]   BETA_RST   = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_PERIOD    = 2'd0,
    CFG_ALPHA_GAIN       = 2'd1,
    CFG_BETA_OVER_PERIOD = 2'd2
  } aabt_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_ERR,
    ST_ALPHA,
    ST_BETA,
    ST_UPD
  } aabt_state_e;

  typedef enum logic [1:0] {
    MUL_PRED,
    MUL_ALPHA,
    MUL_BETA
  } aabt_mul_sel_e;

  typedef struct packed {
    logic          load_meas;
    logic          mul_en;
    aabt_mul_sel_e mul_sel;
    logic          calc_err;
    logic          calc_angle;
    logic          commit;
  } aabt_cmd_t;

  typedef struct packed {
    logic out_free;
  } aabt_status_t;

endpackage

### rtl/core/aabt_if.sv
// handshake interfaces for the measured angle and the estimate channels
interface aabt_meas_if import aabt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] measured_angle;

  modport source (output valid, output measured_angle, input ready);
  modport sink   (input valid, input measured_angle, output ready);
endinterface

interface aabt_est_if import aabt_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [ANGLE_W-1:0]        angle_estimate;
  logic signed [SPEED_W-1:0] speed_estimate;

  modport source (output valid, output angle_estimate, output speed_estimate, input ready);
  modport sink   (input valid, input angle_estimate, input speed_estimate, output ready);
endinterface

### rtl/core/aabt_ctrl.sv
// sequencer of the tracker: steps one item through the shared multiplier
module aabt_ctrl import aabt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  aabt_status_t status_i,
  output aabt_cmd_t    cmd_o
);

  aabt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_PRED;
      ST_PRED:  state_d = ST_ERR;
      ST_ERR:   state_d = ST_ALPHA;
      ST_ALPHA: state_d = ST_BETA;
      ST_BETA:  state_d = ST_UPD;
      ST_UPD:   if (status_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_meas = in_valid_i;
      end
      ST_PRED: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_PRED;
      end
      ST_ERR: begin
        cmd_o.calc_err = 1'b1;
      end
      ST_ALPHA: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ALPHA;
      end
      ST_BETA: begin
        cmd_o.mul_en     = 1'b1;
        cmd_o.mul_sel    = MUL_BETA;
        cmd_o.calc_angle = 1'b1;
      end
      ST_UPD: begin
        cmd_o.commit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

### rtl/core/aabt_datapath.sv
// datapath of the tracker: gain registers, state, shared multiplier, output register
module aabt_datapath import aabt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic [ANGLE_W-1:0]        meas_i,
  input  aabt_cmd_t                 cmd_i,
  output aabt_status_t              status_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ANGLE_W-1:0]        angle_o,
  output logic signed [SPEED_W-1:0] speed_o
);

  logic [PERIOD_W-1:0] period_q;
  logic [ALPHA_W-1:0]  alpha_q;
  logic [BETA_W-1:0]   beta_q;
  logic [ANGLE_W-1:0]  angle_q;
  logic signed [SPEED_W-1:0] speed_q;
  logic                out_valid_q;

  logic [ANGLE_W-1:0]  meas_q;
  logic [PROD_W-1:0]   prod_q;
  logic [ANGLE_W-1:0]  pred_q;
  logic [ANGLE_W-1:0]  err_q;
  logic [ANGLE_W-1:0]  angle_new_q;
  logic [ANGLE_W-1:0]  out_angle_q;
  logic signed [SPEED_W-1:0] out_speed_q;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_full;
  logic [47:0]               pred_sum;
  logic [ANGLE_W-1:0]        pred_d;
  logic [ANGLE_W-1:0]        err_d;
  logic [39:0]               alpha_sum;
  logic [PROD_W-1:0]         beta_sum;
  logic signed [SPEED_W:0]   speed_corr;
  logic signed [SPEED_W+1:0] speed_sum;
  logic signed [SPEED_W-1:0] speed_d;

  // operand select for the one shared multiplier
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_PRED: begin
        mul_a = {speed_q[SPEED_W-1], speed_q};
        mul_b = {1'b0, period_q};
      end
      MUL_ALPHA: begin
        mul_a = {{(MUL_W-ANGLE_W){err_q[ANGLE_W-1]}}, err_q};
        mul_b = {{(MUL_W-ALPHA_W){1'b0}}, alpha_q};
      end
      MUL_BETA: begin
        mul_a = {{(MUL_W-ANGLE_W){err_q[ANGLE_W-1]}}, err_q};
        mul_b = {1'b0, beta_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // prediction: round speed times period to Q0.24, wrap
  assign pred_sum = prod_q[47:0] + RND_24[47:0];
  assign pred_d   = angle_q + pred_sum[47:24];
  assign err_d    = meas_q - pred_d;

  // angle correction rounded from Q.40
  assign alpha_sum = prod_q[39:0] + RND_16[39:0];

  // speed correction rounded from Q.40, then saturated add
  assign beta_sum   = prod_q + RND_24;
  assign speed_corr = $signed(beta_sum[PROD_W-1:24]);
  assign speed_sum  = {{2{speed_q[SPEED_W-1]}}, speed_q}
                    + {speed_corr[SPEED_W], speed_corr};

  always_comb begin
    if (speed_sum[SPEED_W+1:SPEED_W-1] == 3'b000 || speed_sum[SPEED_W+1:SPEED_W-1] == 3'b111) begin
      speed_d = speed_sum[SPEED_W-1:0];
    end else if (speed_sum[SPEED_W+1]) begin
      speed_d = SPEED_MIN;
    end else begin
      speed_d = SPEED_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      alpha_q  <= ALPHA_RST;
      beta_q   <= BETA_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SAMPLE_PERIOD:    period_q <= cfg_data_i[PERIOD_W-1:0];
        CFG_ALPHA_GAIN:       alpha_q  <= cfg_data_i[ALPHA_W-1:0];
        CFG_BETA_OVER_PERIOD: beta_q   <= cfg_data_i[BETA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q     <= ANGLE_RST;
      speed_q     <= SPEED_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        angle_q     <= angle_new_q;
        speed_q     <= speed_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_meas) meas_q <= meas_i;
    if (cmd_i.mul_en) prod_q <= mul_full[PROD_W-1:0];
    if (cmd_i.calc_err) begin
      pred_q <= pred_d;
      err_q  <= err_d;
    end
    if (cmd_i.calc_angle) angle_new_q <= pred_q + alpha_sum[39:16];
    if (cmd_i.commit) begin
      out_angle_q <= angle_new_q;
      out_speed_q <= speed_d;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign angle_o           = out_angle_q;
  assign speed_o           = out_speed_q;

endmodule

### rtl/core/angle_alpha_beta_tracker.sv
// top level of the angle alpha-beta tracker
//
// usage
//   meas_i carries one measured rotor angle per item (unsigned Q0.24 turns).
//   est_o returns one item per input: the filtered angle (Q0.24 turns) and
//   the filtered speed (signed Q16.16 turns per second, saturating).
//   gains and sample period are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i while the block is idle; index 0 period, 1 alpha, 2 beta over
//   period, index 3 is ignored
// timing
//   an item steps through the prediction, error, alpha, beta and update states
//   one item at a time: the single shared multiplier forms the
//   speed-times-period, error-times-alpha and error-times-beta products in turn
//   meas_i.ready is high only while the sequencer waits for an item
// reset
//   angle and speed estimates clear to zero, period returns to 214748, gains to zero
// stalls
//   the output register holds a finished estimate while est_o.ready is low;
//   the next item is still taken and worked through, and only its final
//   update waits until the held estimate has gone
module angle_alpha_beta_tracker import aabt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  aabt_meas_if.sink            meas_i,
  aabt_est_if.source           est_o
);

  aabt_cmd_t    cmd;
  aabt_status_t status;
  logic         in_ready;

  // sequencer
  aabt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (meas_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic, state and output register
  aabt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .meas_i      (meas_i.measured_angle),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (est_o.valid),
    .out_ready_i (est_o.ready),
    .angle_o     (est_o.angle_estimate),
    .speed_o     (est_o.speed_estimate)
  );

  assign meas_i.ready = in_ready;

`ifndef SYNTHESIS
  // sequencer is busy for the cycle after an item is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meas_i.valid && meas_i.ready |=> !meas_i.ready)
    else $error("input taken while an item is still in work");

  // a new estimate never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!est_o.valid || est_o.ready))
    else $error("estimate overwritten before it was taken");

  // load, error, angle and commit steps of the datapath are issued one at a time
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_meas, cmd.calc_err, cmd.calc_angle, cmd.commit}))
    else $error("more than one datapath step in a cycle");
`endif

endmodule

### tb/aabt_estimate_check.sv
// watches the tracker channels, predicts every estimate and compares it with the one returned
`timescale 1ns / 100ps
module aabt_estimate_check import aabt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  aabt_meas_if                 meas,
  aabt_est_if                  est,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  localparam longint HALF_LSB = 64'sd8388608;

  typedef struct packed {
    logic [ANGLE_W-1:0]        angle;
    logic signed [SPEED_W-1:0] speed;
  } estimate_t;

  logic [PERIOD_W-1:0]       period_q;
  logic [ALPHA_W-1:0]        alpha_q;
  logic [BETA_W-1:0]         beta_q;
  logic [ANGLE_W-1:0]        angle_q;
  logic signed [SPEED_W-1:0] speed_q;

  estimate_t   estimates_due[$];
  int unsigned mismatches;

  assign fail_count_o = mismatches;

  // one filter step from the current state, all rounding half up
  function automatic estimate_t next_estimate(input logic [ANGLE_W-1:0] meas_angle);
    longint                    spd;
    longint                    per;
    longint                    err;
    longint                    alp;
    longint                    bet;
    longint                    acorr;
    longint                    scorr;
    longint                    sum;
    logic [63:0]               pu;
    logic [ANGLE_W-1:0]        pred;
    logic [ANGLE_W-1:0]        diff;
    logic signed [ANGLE_W-1:0] diff_s;
    estimate_t                 res;
    spd = speed_q;
    per = period_q;
    pu = 64'(spd * per) + 64'h800000;
    pred = angle_q + pu[47:24];
    diff = meas_angle - pred;
    diff_s = diff;
    err = diff_s;
    alp = alpha_q;
    bet = beta_q;
    acorr = (err * alp * 256 + HALF_LSB) >>> 24;
    res.angle = pred + acorr[23:0];
    scorr = (err * bet + HALF_LSB) >>> 24;
    sum = spd + scorr;
    if (sum > SPEED_MAX) begin
      res.speed = SPEED_MAX;
    end else if (sum < SPEED_MIN) begin
      res.speed = SPEED_MIN;
    end else begin
      res.speed = sum[31:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    estimate_t nxt;
    estimate_t due;
    if (!rst_ni) begin
      period_q   = PERIOD_RST;
      alpha_q    = ALPHA_RST;
      beta_q     = BETA_RST;
      angle_q    = ANGLE_RST;
      speed_q    = SPEED_RST;
      mismatches = 0;
      estimates_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SAMPLE_PERIOD:    period_q = cfg_data_i;
          CFG_ALPHA_GAIN:       alpha_q  = cfg_data_i[ALPHA_W-1:0];
          CFG_BETA_OVER_PERIOD: beta_q   = cfg_data_i;
          default: ;
        endcase
      end
      if (meas.valid && meas.ready) begin
        nxt = next_estimate(meas.measured_angle);
        angle_q = nxt.angle;
        speed_q = nxt.speed;
        estimates_due.push_back(nxt);
      end
      if (est.valid && est.ready) begin
        if (estimates_due.size() == 0) begin
          $display("%0t: estimate with none due, angle %h speed %h", $time,
                   est.angle_estimate, est.speed_estimate);
          mismatches++;
        end else begin
          due = estimates_due.pop_front();
          if (est.angle_estimate !== due.angle) begin
            $display("%0t: angle_estimate expected %h actual %h", $time,
                     due.angle, est.angle_estimate);
            mismatches++;
          end
          if (est.speed_estimate !== due.speed) begin
            $display("%0t: speed_estimate expected %h actual %h", $time,
                     due.speed, est.speed_estimate);
            mismatches++;
          end
        end
      end
      pending_o <= estimates_due.size();
    end
  end

endmodule

### tb/tb_angle_alpha_beta_tracker.sv
// stimulus and verdict for the angle alpha-beta tracker
`timescale 1ns / 100ps
module tb_angle_alpha_beta_tracker;
  import aabt_pkg::*;

  localparam int unsigned LATENCY    = 6;
  // far above the longest quiet stretch of a correct run
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned PHASES     = 16;
  localparam int unsigned PER_PHASE  = 110;
  // the fourth index has no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  aabt_meas_if meas ();
  aabt_est_if  est ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles;
  int          send_idle_pct;
  int          stall_pct;

  // rotor model behind the well-formed part of the stimulus
  logic [ANGLE_W-1:0] rotor_angle;
  logic [ANGLE_W-1:0] rotor_rate;

  angle_alpha_beta_tracker uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .meas_i     (meas),
    .est_o      (est)
  );

  aabt_estimate_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .meas         (meas),
    .est          (est),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // receiver side: stall at the rate of the current phase
  always @(posedge clk_i) begin
    est.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: a run that stops moving items is a failure
  always @(posedge clk_i) begin
    if ((meas.valid && meas.ready) || (est.valid && est.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("angle_alpha_beta_tracker test failed");
      $finish;
    end
  end

  // offer one measured angle, with random gaps first, and hold until taken;
  // valid stays high on return so back-to-back items never drop it
  task automatic send_angle(input logic [ANGLE_W-1:0] angle);
    while ($urandom_range(99) < send_idle_pct) begin
      meas.valid <= 1'b0;
      @(posedge clk_i);
    end
    meas.valid          <= 1'b1;
    meas.measured_angle <= angle;
    @(posedge clk_i);
    while (!meas.ready) @(posedge clk_i);
  endtask

  // stop sending, let every due estimate arrive and the block fall idle
  task automatic drain;
    meas.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // one register write per cycle, enable dropped after the last
  task automatic write_regs(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] alpha,
                            input logic [CFG_W-1:0] beta, input bit poke_unused);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SAMPLE_PERIOD;
    cfg_data_i <= period;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ALPHA_GAIN;
    cfg_data_i <= alpha;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BETA_OVER_PERIOD;
    cfg_data_i <= beta;
    @(posedge clk_i);
    if (poke_unused) begin
      cfg_idx_i  <= CFG_UNUSED;
      cfg_data_i <= $urandom;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin
        send_idle_pct <= 0;
        stall_pct     <= 0;
      end
      1: begin
        send_idle_pct <= 67;
        stall_pct     <= 0;
      end
      2: begin
        send_idle_pct <= 0;
        stall_pct     <= 67;
      end
      default: begin
        send_idle_pct <= 13;
        stall_pct     <= 13;
      end
    endcase
  endtask

  // mostly a turning rotor with small noise, with full-range jumps and
  // half-turn flips mixed in that break the tracking
  function automatic logic [ANGLE_W-1:0] rotor_sample(input logic [ANGLE_W-1:0] last);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      rotor_angle = rotor_angle + rotor_rate;
      return rotor_angle + ANGLE_W'($urandom_range(511)) - 24'd256;
    end else if (pick < 88) begin
      return ANGLE_W'($urandom);
    end
    return last ^ 24'h800000;
  endfunction

  initial begin
    logic [CFG_W-1:0]   period;
    logic [CFG_W-1:0]   alpha;
    logic [CFG_W-1:0]   beta;
    logic [ANGLE_W-1:0] last;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_SAMPLE_PERIOD;
    cfg_data_i          <= '0;
    meas.valid          <= 1'b0;
    meas.measured_angle <= '0;
    send_idle_pct       <= 0;
    stall_pct           <= 0;
    rotor_angle = '0;
    rotor_rate  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: no gains, so the estimate only coasts
    send_angle(24'h000000);
    send_angle(24'h123456);
    send_angle(24'hFFFFFF);
    drain();

    // longest period, unity alpha, largest beta: speed runs into its bounds
    write_regs(32'hFFFF_FFFF, 32'd65536, 32'hFFFF_FFFF, 1'b0);
    send_angle(24'h7FFFFF);
    send_angle(24'h000000);
    send_angle(24'hFFFFFF);
    send_angle(24'h800000);
    send_angle(24'h7FFFFF);
    drain();

    // zero period with unity alpha makes the estimate equal the measurement,
    // so flipping the top bit gives an error of exactly half a turn
    write_regs(32'd0, 32'd65536, 32'hFFFF_FFFF, 1'b1);
    send_angle(24'h000000);
    send_angle(24'h800000);
    send_angle(24'h000000);
    send_angle(24'h800000);
    send_angle(24'h7FFFFF);
    send_angle(24'hFFFFFE);
    send_angle(24'h7FFFFE);
    drain();

    // alpha above one from an over-wide write, smallest nonzero period and beta
    write_regs(32'd1, 32'hFFFF_FFFF, 32'd1, 1'b1);
    send_angle(24'h555555);
    send_angle(24'hAAAAAA);
    send_angle(24'h000001);
    send_angle(24'hFFFFFF);
    send_angle(24'h400000);
    drain();

    // random part: each phase a new setting, idling mode in rotation
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(4))
        0:       period = '0;
        1:       period = 32'd1;
        2:       period = '1;
        3:       period = 32'd214748;
        default: period = $urandom >> $urandom_range(31);
      endcase
      case ($urandom_range(4))
        0:       alpha = '0;
        1:       alpha = 32'd65536;
        2:       alpha = 32'h1FFFF;
        3:       alpha = $urandom;
        default: alpha = $urandom_range(65536);
      endcase
      case ($urandom_range(3))
        0:       beta = '0;
        1:       beta = '1;
        2:       beta = $urandom;
        default: beta = $urandom >> $urandom_range(31);
      endcase
      write_regs(period, alpha, beta, $urandom_range(1));
      set_idling(ph % 4);
      rotor_rate = ANGLE_W'($urandom) >> $urandom_range(23);
      if ($urandom_range(1)) begin
        rotor_rate = -rotor_rate;
      end
      last = rotor_angle;
      for (int unsigned n = 0; n < PER_PHASE; n++) begin
        // hold off once until every estimate has come back
        if (ph == 5 && n == PER_PHASE / 2) begin
          drain();
        end
        last = rotor_sample(last);
        send_angle(last);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("angle_alpha_beta_tracker test passed");
    end else begin
      $display("angle_alpha_beta_tracker test failed");
    end
    $finish;
  end

endmodule
